[src/qss_pkg.sv]
// Shared constants, register indexes and types for the quad scanline span block.
package qss_pkg;

  // Default coordinate format: signed Q31.8.
  localparam int COORD_W_DEF = 40;
  localparam int FRAC_DEF    = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TL_EAST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TL_NORTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TR_EAST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TR_NORTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BL_EAST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BL_NORTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BR_EAST  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BR_NORTH = 3'd7;

  // Per-item outcome travelling alongside the arithmetic.
  typedef struct packed {
    logic fit;
    logic err;
  } qss_flags_t;

endpackage

[src/quad_scanline_span.sv]
// Top level of the quad scanline span unit.
//
// Usage: write the eight corner registers (indexes 0 to 7: top-left east and
// north, top-right, bottom-left, bottom-right) through the cfg_ channel while
// the block is idle; cfg_ready is always high. Each transfer on the in_
// channel carries one line northing and produces exactly one result on the
// out_ channel: fit flag, left and right crossing eastings and edge error.
// The path runs through the edge selection register, the multiplier, then a
// row of COORD_WIDTH division cells, one per quotient bit, and finally the
// rounding and output register. The whole pipeline advances together.
// Throughput is one item per cycle unless out_stall holds back a result.
// When the receiver holds out_stall with a result waiting, the pipeline
// freezes and in_stall is raised in the same cycle; nothing is lost.
// Reset clears all valid bits and zeroes the corner registers.
module quad_scanline_span import qss_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int FRAC_BITS   = FRAC_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_line_north,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_fit,
  output logic [COORD_WIDTH-1:0] out_span_left,
  output logic [COORD_WIDTH-1:0] out_span_right,
  output logic                   out_edge_error,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int W = COORD_WIDTH;
  localparam logic [W-1:0] ONE_UNIT = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] EMPTY_R  = W'(0) - ONE_UNIT;

  logic en;

  logic [W-1:0] tl_e_r, tl_n_r, tr_e_r, tr_n_r, bl_e_r, bl_n_r, br_e_r, br_n_r;

  logic [W-1:0] fl_num, fl_mag, fl_den, fl_elo, fr_num, fr_mag, fr_den, fr_elo;
  logic         fl_up, fr_up;
  qss_flags_t   f_flags;

  logic [2*W-1:0] ml_p, mr_p;

  logic [W-1:0] l_rem [0:W];
  logic [W-1:0] l_lo  [0:W];
  logic [W-1:0] l_den [0:W];
  logic [W-1:0] l_elo [0:W];
  logic         l_up  [0:W];
  logic [W-1:0] r_rem [0:W];
  logic [W-1:0] r_lo  [0:W];
  logic [W-1:0] r_den [0:W];
  logic [W-1:0] r_elo [0:W];
  logic         r_up  [0:W];

  logic [W+2:0] vld_r;
  qss_flags_t   fl_r [0:W+1];

  logic         out_valid_r, out_fit_r, out_err_r;
  logic [W-1:0] out_left_r, out_right_r;
  logic [W-1:0] left_end, right_end;

  // Rounded end of the interpolation; a zero-height edge gives its lower easting.
  function automatic logic [W-1:0] span_end(input logic [W-1:0] rem,
                                            input logic [W-1:0] quo,
                                            input logic [W-1:0] den,
                                            input logic [W-1:0] elo,
                                            input logic         up);
    logic [W-1:0] q1;
    begin
      q1 = quo + W'(rem >= (den - rem));
      if (den == '0) begin
        span_end = elo;
      end else if (up) begin
        span_end = elo + q1;
      end else begin
        span_end = elo - q1;
      end
    end
  endfunction

  // The whole pipeline moves unless a finished result is held back.
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Corner registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_e_r <= '0; tl_n_r <= '0; tr_e_r <= '0; tr_n_r <= '0;
      bl_e_r <= '0; bl_n_r <= '0; br_e_r <= '0; br_n_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TL_EAST:  tl_e_r <= cfg_data;
        REG_TL_NORTH: tl_n_r <= cfg_data;
        REG_TR_EAST:  tr_e_r <= cfg_data;
        REG_TR_NORTH: tr_n_r <= cfg_data;
        REG_BL_EAST:  bl_e_r <= cfg_data;
        REG_BL_NORTH: bl_n_r <= cfg_data;
        REG_BR_EAST:  br_e_r <= cfg_data;
        REG_BR_NORTH: br_n_r <= cfg_data;
        default: ;
      endcase
    end
  end

  qss_front #(.W(W)) u_front (
    .clk(clk), .en(en), .line_north(in_line_north),
    .tl_e(tl_e_r), .tl_n(tl_n_r), .tr_e(tr_e_r), .tr_n(tr_n_r),
    .bl_e(bl_e_r), .bl_n(bl_n_r), .br_e(br_e_r), .br_n(br_n_r),
    .l_num_o(fl_num), .l_mag_o(fl_mag), .l_den_o(fl_den), .l_elo_o(fl_elo),
    .l_up_o(fl_up),
    .r_num_o(fr_num), .r_mag_o(fr_mag), .r_den_o(fr_den), .r_elo_o(fr_elo),
    .r_up_o(fr_up),
    .flags_o(f_flags)
  );

  qss_mul #(.W(W)) u_mul_l (
    .clk(clk), .en(en), .a_i(fl_num), .b_i(fl_mag), .den_i(fl_den),
    .elo_i(fl_elo), .up_i(fl_up),
    .p_o(ml_p), .den_o(l_den[0]), .elo_o(l_elo[0]), .up_o(l_up[0])
  );

  qss_mul #(.W(W)) u_mul_r (
    .clk(clk), .en(en), .a_i(fr_num), .b_i(fr_mag), .den_i(fr_den),
    .elo_i(fr_elo), .up_i(fr_up),
    .p_o(mr_p), .den_o(r_den[0]), .elo_o(r_elo[0]), .up_o(r_up[0])
  );

  // The product's upper half is already below the divisor.
  assign l_rem[0] = ml_p[2*W-1:W];
  assign l_lo[0]  = ml_p[W-1:0];
  assign r_rem[0] = mr_p[2*W-1:W];
  assign r_lo[0]  = mr_p[W-1:0];

  // Division rows, one cell per quotient bit for each span end.
  for (genvar k = 0; k < W; k++) begin : g_div
    qss_cell #(.W(W)) u_cell_l (
      .clk(clk), .en(en),
      .rem_i(l_rem[k]), .lo_i(l_lo[k]), .den_i(l_den[k]), .elo_i(l_elo[k]),
      .up_i(l_up[k]),
      .rem_o(l_rem[k+1]), .lo_o(l_lo[k+1]), .den_o(l_den[k+1]),
      .elo_o(l_elo[k+1]), .up_o(l_up[k+1])
    );
    qss_cell #(.W(W)) u_cell_r (
      .clk(clk), .en(en),
      .rem_i(r_rem[k]), .lo_i(r_lo[k]), .den_i(r_den[k]), .elo_i(r_elo[k]),
      .up_i(r_up[k]),
      .rem_o(r_rem[k+1]), .lo_o(r_lo[k+1]), .den_o(r_den[k+1]),
      .elo_o(r_elo[k+1]), .up_o(r_up[k+1])
    );
  end

  // Valid bits and outcome flags travel beside the arithmetic.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[W+1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= f_flags;
      for (int i = 1; i < W + 2; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  assign left_end  = span_end(l_rem[W], l_lo[W], l_den[W], l_elo[W], l_up[W]);
  assign right_end = span_end(r_rem[W], r_lo[W], r_den[W], r_elo[W], r_up[W]);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[W+2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_fit_r   <= fl_r[W+1].fit;
      out_err_r   <= fl_r[W+1].err;
      out_left_r  <= fl_r[W+1].fit ? left_end : '0;
      out_right_r <= fl_r[W+1].fit ? right_end : EMPTY_R;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fit        = out_fit_r;
  assign out_edge_error = out_err_r;
  assign out_span_left  = out_left_r;
  assign out_span_right = out_right_r;

`ifndef SYNTH
  a_fit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fit && out_edge_error))
    else $error("fit and edge error both set");

  a_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fit) |-> (out_span_left == '0 && out_span_right == EMPTY_R))
    else $error("no-fit result without empty span");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_span_left)
                                  && $stable(out_span_right)))
    else $error("stalled result changed");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (out_valid == $past(vld_r[W+2])))
    else $error("output valid out of step with the pipeline");
`endif

endmodule

[src/qss_front.sv]
// Edge selection and edge differences for both span ends.
module qss_front import qss_pkg::*; #(
  parameter int W = COORD_W_DEF
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] line_north,
  input  logic [W-1:0] tl_e,
  input  logic [W-1:0] tl_n,
  input  logic [W-1:0] tr_e,
  input  logic [W-1:0] tr_n,
  input  logic [W-1:0] bl_e,
  input  logic [W-1:0] bl_n,
  input  logic [W-1:0] br_e,
  input  logic [W-1:0] br_n,
  output logic [W-1:0] l_num_o,
  output logic [W-1:0] l_mag_o,
  output logic [W-1:0] l_den_o,
  output logic [W-1:0] l_elo_o,
  output logic         l_up_o,
  output logic [W-1:0] r_num_o,
  output logic [W-1:0] r_mag_o,
  output logic [W-1:0] r_den_o,
  output logic [W-1:0] r_elo_o,
  output logic         r_up_o,
  output qss_flags_t   flags_o
);

  logic signed [W-1:0] n, tln, trn, bln, brn;
  logic signed [W-1:0] lnl, lnh, lel, leh, rnl, rnh, rel, reh;
  logic lc1, lc2, lc3, rc1, rc2, rc3, nofit, err;
  logic l_up, r_up;
  logic [W-1:0] l_num, l_den, l_mag, r_num, r_den, r_mag;

  logic [W-1:0] l_num_r, l_mag_r, l_den_r, l_elo_r;
  logic [W-1:0] r_num_r, r_mag_r, r_den_r, r_elo_r;
  logic         l_up_r, r_up_r;
  qss_flags_t   flags_r;

  assign n   = $signed(line_north);
  assign tln = $signed(tl_n);
  assign trn = $signed(tr_n);
  assign bln = $signed(bl_n);
  assign brn = $signed(br_n);

  // Which edge each side of the line crosses.
  assign lc1 = (bln <= n) && (n <= tln);
  assign lc2 = (brn <= n) && (n <= bln);
  assign lc3 = (tln <= n) && (n <= trn);
  assign rc1 = (brn <= n) && (n <= trn);
  assign rc2 = (bln <= n) && (n <= brn);
  assign rc3 = (trn <= n) && (n <= tln);

  assign nofit = ((tln < n) && (trn < n)) || ((n < bln) && (n < brn));
  assign err   = !nofit && !((lc1 || lc2 || lc3) && (rc1 || rc2 || rc3));

  // Lower and upper corner of the chosen edge on each side.
  always_comb begin
    if (lc1) begin
      lnl = bln; lel = $signed(bl_e); lnh = tln; leh = $signed(tl_e);
    end else if (lc2) begin
      lnl = brn; lel = $signed(br_e); lnh = bln; leh = $signed(bl_e);
    end else begin
      lnl = tln; lel = $signed(tl_e); lnh = trn; leh = $signed(tr_e);
    end
    if (rc1) begin
      rnl = brn; rel = $signed(br_e); rnh = trn; reh = $signed(tr_e);
    end else if (rc2) begin
      rnl = bln; rel = $signed(bl_e); rnh = brn; reh = $signed(br_e);
    end else begin
      rnl = trn; rel = $signed(tr_e); rnh = tln; reh = $signed(tl_e);
    end
  end

  // Differences are non-negative and below 2**W, so W bits hold them.
  assign l_up  = lel <= leh;
  assign r_up  = rel <= reh;
  assign l_num = n - lnl;
  assign l_den = lnh - lnl;
  assign l_mag = l_up ? (leh - lel) : (lel - leh);
  assign r_num = n - rnl;
  assign r_den = rnh - rnl;
  assign r_mag = r_up ? (reh - rel) : (rel - reh);

  always_ff @(posedge clk) begin
    if (en) begin
      l_num_r     <= l_num;
      l_den_r     <= l_den;
      l_mag_r     <= l_mag;
      l_elo_r     <= lel;
      l_up_r      <= l_up;
      r_num_r     <= r_num;
      r_den_r     <= r_den;
      r_mag_r     <= r_mag;
      r_elo_r     <= rel;
      r_up_r      <= r_up;
      flags_r.fit <= !nofit && !err;
      flags_r.err <= err;
    end
  end

  assign l_num_o = l_num_r;
  assign l_mag_o = l_mag_r;
  assign l_den_o = l_den_r;
  assign l_elo_o = l_elo_r;
  assign l_up_o  = l_up_r;
  assign r_num_o = r_num_r;
  assign r_mag_o = r_mag_r;
  assign r_den_o = r_den_r;
  assign r_elo_o = r_elo_r;
  assign r_up_o  = r_up_r;
  assign flags_o = flags_r;

endmodule

[src/qss_mul.sv]
// Two-stage unsigned multiplier built from four half-width partial products.
module qss_mul import qss_pkg::*; #(
  parameter int W = COORD_W_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  input  logic [W-1:0]   den_i,
  input  logic [W-1:0]   elo_i,
  input  logic           up_i,
  output logic [2*W-1:0] p_o,
  output logic [W-1:0]   den_o,
  output logic [W-1:0]   elo_o,
  output logic           up_o
);

  localparam int H = (W + 1) / 2;

  logic [2*H-1:0] a_ext, b_ext;
  logic [4*H-1:0] sum;
  logic [2*H-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [W-1:0]   den1_r, elo1_r, den2_r, elo2_r;
  logic           up1_r, up2_r;
  logic [2*W-1:0] p_r;

  assign a_ext = (2*H)'(a_i);
  assign b_ext = (2*H)'(b_i);

  // First stage: partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= a_ext[H-1:0]   * b_ext[H-1:0];
      lh_r   <= a_ext[H-1:0]   * b_ext[2*H-1:H];
      hl_r   <= a_ext[2*H-1:H] * b_ext[H-1:0];
      hh_r   <= a_ext[2*H-1:H] * b_ext[2*H-1:H];
      den1_r <= den_i;
      elo1_r <= elo_i;
      up1_r  <= up_i;
    end
  end

  // Second stage: combine the partial products.
  assign sum = (4*H)'(ll_r) + ((4*H)'(lh_r) << H) + ((4*H)'(hl_r) << H)
             + ((4*H)'(hh_r) << (2*H));

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= sum[2*W-1:0];
      den2_r <= den1_r;
      elo2_r <= elo1_r;
      up2_r  <= up1_r;
    end
  end

  assign p_o   = p_r;
  assign den_o = den2_r;
  assign elo_o = elo2_r;
  assign up_o  = up2_r;

endmodule

[src/qss_cell.sv]
// One restoring-division cell: settles one quotient bit per cycle while en is high.
module qss_cell import qss_pkg::*; #(
  parameter int W = COORD_W_DEF
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] lo_i,
  input  logic [W-1:0] den_i,
  input  logic [W-1:0] elo_i,
  input  logic         up_i,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] lo_o,
  output logic [W-1:0] den_o,
  output logic [W-1:0] elo_o,
  output logic         up_o
);

  logic [W:0]   trial, diff;
  logic         ge;
  logic [W-1:0] rem_r, lo_r, den_r, elo_r;
  logic         up_r;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_i, lo_i[W-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = !diff[W];

  // The quotient bit shifts in where the dividend bit left.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      lo_r  <= {lo_i[W-2:0], ge};
      den_r <= den_i;
      elo_r <= elo_i;
      up_r  <= up_i;
    end
  end

  assign rem_o = rem_r;
  assign lo_o  = lo_r;
  assign den_o = den_r;
  assign elo_o = elo_r;
  assign up_o  = up_r;

endmodule

[bench/tb.sv]
// Self-checking testbench for the quad scanline span block.
module tb;
  import qss_pkg::*;

  localparam int CW        = COORD_W_DEF;
  localparam int FB        = FRAC_DEF;
  localparam int LIMIT     = 300000;
  localparam int TAIL      = CW + 10;

  typedef struct packed {
    logic          fit;
    logic [CW-1:0] left;
    logic [CW-1:0] right;
    logic          err;
  } span_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CW-1:0]        in_line_north = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_fit;
  logic [CW-1:0]        out_span_left;
  logic [CW-1:0]        out_span_right;
  logic                 out_edge_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]        cfg_data = '0;

  // Local copy of the corner registers, indexed by register index.
  logic signed [CW-1:0] corner [8];
  span_t span_q [$];
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_len = 0;
  int    cycles = 0;
  bit    failed = 0;

  quad_scanline_span u_top (.*);

  always #2 clk = ~clk;

  // Crossing easting along one edge, exact with rounding half away from zero.
  function automatic logic [CW-1:0] edge_cross(longint n, longint elo, longint nlo,
                                               longint ehi, longint nhi);
    longint     den, num, mag;
    bit [127:0] prod, quo, rem;
    bit         up;
    den = nhi - nlo;
    if (den == 0) return elo[CW-1:0];
    num  = n - nlo;
    up   = (elo <= ehi);
    mag  = up ? ehi - elo : elo - ehi;
    prod = 128'(num) * 128'(mag);
    quo  = prod / 128'(den);
    rem  = prod - quo * 128'(den);
    if (rem >= 128'(den) - rem) quo = quo + 1;
    return up ? CW'(elo + longint'(quo)) : CW'(elo - longint'(quo));
  endfunction

  // Expected span for one line against the current corners.
  function automatic span_t predict_span(logic [CW-1:0] line);
    longint n, tle, tln, tre, trn, ble, bln, bre, brn;
    span_t  s;
    n   = longint'($signed(line));
    tle = corner[REG_TL_EAST];  tln = corner[REG_TL_NORTH];
    tre = corner[REG_TR_EAST];  trn = corner[REG_TR_NORTH];
    ble = corner[REG_BL_EAST];  bln = corner[REG_BL_NORTH];
    bre = corner[REG_BR_EAST];  brn = corner[REG_BR_NORTH];
    s.fit   = 1'b0;
    s.left  = '0;
    s.right = -(CW'(1) << FB);
    s.err   = 1'b0;
    if ((n > tln && n > trn) || (n < bln && n < brn)) return s;
    if (bln <= n && n <= tln)      s.left = edge_cross(n, ble, bln, tle, tln);
    else if (brn <= n && n <= bln) s.left = edge_cross(n, bre, brn, ble, bln);
    else if (tln <= n && n <= trn) s.left = edge_cross(n, tle, tln, tre, trn);
    else begin
      s.err = 1'b1;
      return s;
    end
    if (brn <= n && n <= trn)      s.right = edge_cross(n, bre, brn, tre, trn);
    else if (bln <= n && n <= brn) s.right = edge_cross(n, ble, bln, bre, brn);
    else if (trn <= n && n <= tln) s.right = edge_cross(n, tre, trn, tle, tln);
    else begin
      s.left = '0;
      s.err  = 1'b1;
      return s;
    end
    s.fit = 1'b1;
    return s;
  endfunction

  // Signed random value of bits + 1 bits, from -2**bits to 2**bits - 1.
  function automatic longint rand_coord(int bits);
    longint v;
    v = longint'({$urandom, $urandom});
    return (v <<< (63 - bits)) >>> (63 - bits);
  endfunction

  // One register write on the configuration channel.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CW-1:0];
    do @(posedge clk); while (!cfg_ready);
    corner[idx] = value[CW-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_quad(longint tle, tln, tre, trn, ble, bln, bre, brn);
    write_reg(REG_TL_EAST, tle);  write_reg(REG_TL_NORTH, tln);
    write_reg(REG_TR_EAST, tre);  write_reg(REG_TR_NORTH, trn);
    write_reg(REG_BL_EAST, ble);  write_reg(REG_BL_NORTH, bln);
    write_reg(REG_BR_EAST, bre);  write_reg(REG_BR_NORTH, brn);
  endtask

  // Offer one line and wait for its transfer; valid stays high for a follow-on item.
  task automatic send_line(longint line);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_line_north = CW'({$urandom, $urandom});
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_line_north = line[CW-1:0];
    do @(posedge clk); while (in_stall);
    span_q.push_back(predict_span(line[CW-1:0]));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drain();
    stop_sending();
    while (span_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // Receiver: long hold-offs when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len  <= hold_len - 1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (span_q.size() == 0) begin
        $display("%0t: unexpected result fit=%b left=%h right=%h err=%b", $time,
                 out_fit, out_span_left, out_span_right, out_edge_error);
        failed = 1;
      end else begin
        span_t e;
        e = span_q.pop_front();
        if (out_fit !== e.fit) begin
          $display("%0t: fit expected %b actual %b", $time, e.fit, out_fit);
          failed = 1;
        end
        if (out_span_left !== e.left) begin
          $display("%0t: span_left expected %h actual %h", $time, e.left, out_span_left);
          failed = 1;
        end
        if (out_span_right !== e.right) begin
          $display("%0t: span_right expected %h actual %h", $time, e.right,
                   out_span_right);
          failed = 1;
        end
        if (out_edge_error !== e.err) begin
          $display("%0t: edge_error expected %b actual %b", $time, e.err,
                   out_edge_error);
          failed = 1;
        end
      end
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hand-picked quads and lines: corners, outside lines, extremes.
  task automatic test_directed();
    longint mx, mn;
    mx = (longint'(1) <<< (CW - 1)) - 1;
    mn = -(longint'(1) <<< (CW - 1));
    // A plain quad reached through the reset state first.
    send_line(0);
    send_line(mx);
    wait_drain();
    write_quad(0, 1000, 2000, 1200, 100, 0, 1900, -100);
    foreach (corner[i]) send_line(corner[i]);
    send_line(1300);
    send_line(-200);
    send_line(500);
    send_line(1100);
    send_line(-50);
    send_line(mx);
    send_line(mn);
    wait_drain();
    // Full-range corners give the widest products and quotients.
    write_quad(mn, mx, mx, mx - 3, mx, mn, mn, mn + 7);
    send_line(0);
    send_line(mx);
    send_line(mn);
    send_line(mn + 3);
    send_line(mx - 1);
    send_line(1);
    wait_drain();
    // Flat top and bottom edges, and a collapsed quad.
    write_quad(-5, 7, 9, 7, -3, -7, 11, -7);
    send_line(7);
    send_line(-7);
    send_line(0);
    wait_drain();
    write_quad(0, 0, 0, 0, 0, 0, 0, 0);
    send_line(0);
    send_line(-1);
    wait_drain();
  endtask

  task automatic random_quad();
    int     bits, kind;
    longint v [8];
    longint t;
    bits = ($urandom_range(3) == 0) ? CW - 1 : $urandom_range(CW - 1, 2);
    kind = $urandom_range(9);
    foreach (v[i]) v[i] = rand_coord(bits);
    if (kind < 6) begin
      // Well-formed: the top corners lie above the bottom ones.
      if (v[REG_TL_NORTH] < v[REG_BL_NORTH]) begin
        t = v[REG_TL_NORTH]; v[REG_TL_NORTH] = v[REG_BL_NORTH]; v[REG_BL_NORTH] = t;
      end
      if (v[REG_TR_NORTH] < v[REG_BR_NORTH]) begin
        t = v[REG_TR_NORTH]; v[REG_TR_NORTH] = v[REG_BR_NORTH]; v[REG_BR_NORTH] = t;
      end
    end else if (kind < 8) begin
      // Tiny norths so that edges are often flat or crossed.
      v[REG_TL_NORTH] = $signed($urandom_range(8)) - 4;
      v[REG_TR_NORTH] = $signed($urandom_range(8)) - 4;
      v[REG_BL_NORTH] = $signed($urandom_range(8)) - 4;
      v[REG_BR_NORTH] = $signed($urandom_range(8)) - 4;
    end
    write_quad(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endtask

  function automatic longint random_line();
    longint lo, hi, n;
    int     pick;
    pick = $urandom_range(9);
    if (pick < 2) return rand_coord(CW - 1);
    if (pick == 2) return corner[2 * $urandom_range(3) + 1];
    lo = corner[REG_TL_NORTH];
    hi = lo;
    for (int i = 3; i < 8; i += 2) begin
      n = corner[i];
      if (n < lo) lo = n;
      if (n > hi) hi = n;
    end
    n = longint'({1'b0, $urandom, $urandom} % (64'(hi - lo) + 1));
    return lo + n;
  endfunction

  // Random quads and lines under one idling pattern.
  task automatic test_random(int send_pct, int recv_pct, int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        wait_drain();
        random_quad();
      end
      send_line(random_line());
    end
    wait_drain();
  endtask

  // Long receiver hold-off fills the pipeline, then the sender waits it out.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_quad();
    hold_len = 200;
    for (int i = 0; i < 100; i++) send_line(random_line());
    stop_sending();
    while (span_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_line(random_line());
    wait_drain();
  endtask

  initial begin
    foreach (corner[i]) corner[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(38, 67, 520);
    test_random(67, 38, 520);
    test_random(0, 0, 520);
    test_backpressure();
    if (!failed && span_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/qss_pkg.sv
src/qss_front.sv
src/qss_mul.sv
src/qss_cell.sv
src/quad_scanline_span.sv
bench/tb.sv
